// ===== rtl/stbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package stbs_pkg;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 10;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND       = 3'd0,
    CMD_SEARCH_ANY   = 3'd1,
    CMD_SEARCH_FIRST = 3'd2,
    CMD_SEARCH_LAST  = 3'd3,
    CMD_CLEAR        = 3'd4
  } cmd_e;

  // packed so that found sits in bit 0
  typedef struct packed {
    logic refused;
    logic found;
  } res_flags_t;

endpackage

`default_nettype wire

// ===== rtl/stbs_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stbs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/stbs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stbs_ctrl #(
  parameter int unsigned DEPTH       = 1024,
  parameter int unsigned ENTRY_WIDTH = 32,
  localparam int unsigned IDX_W      = $clog2(DEPTH),
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [stbs_pkg::CMD_W-1:0]    in_cmd_i,
  input  wire logic [ENTRY_WIDTH-1:0]        in_key_i,
  output logic                               res_valid_o,
  input  wire logic                          res_ready_i,
  output stbs_pkg::res_flags_t               res_flags_o,
  output logic      [IDX_W-1:0]              res_pos_o,
  output logic                               ram_we_o,
  output logic      [IDX_W-1:0]              ram_waddr_o,
  output logic      [ENTRY_WIDTH-1:0]        ram_wdata_o,
  output logic                               ram_re_o,
  output logic      [IDX_W-1:0]              ram_raddr_o,
  input  wire logic [ENTRY_WIDTH-1:0]        ram_rdata_i
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_PROBE = 3'b010,
    ST_RESP  = 3'b100
  } state_e;

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W-1:0]     lo_q, lo_d, hi_q, hi_d;
  logic [IDX_W-1:0]     mid_q, mid_d;
  logic [ENTRY_WIDTH-1:0] key_q, key_d;
  stbs_pkg::cmd_e       mode_q, mode_d;
  logic                 hit_q, hit_d;
  logic [IDX_W-1:0]     hitpos_q, hitpos_d;
  stbs_pkg::res_flags_t flags_q, flags_d;
  logic [IDX_W-1:0]     pos_q, pos_d;

  logic [CNT_W-1:0]     lo_n, hi_n, mid_ext, mid_inc, next_mid, half_cnt;
  logic                 eq, lt, any_hit;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_RESP);
  assign res_flags_o = flags_q;
  assign res_pos_o   = pos_q;

  assign ram_waddr_o = count_q[IDX_W-1:0];
  assign ram_wdata_o = in_key_i;

  assign eq       = (ram_rdata_i == key_q);
  assign lt       = ($signed(ram_rdata_i) < $signed(key_q));
  assign mid_ext  = CNT_W'(mid_q);
  assign mid_inc  = mid_ext + CNT_W'(1);
  assign half_cnt = count_q >> 1;
  assign next_mid = lo_n + ((hi_n - lo_n) >> 1);

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    mid_d    = mid_q;
    key_d    = key_q;
    mode_d   = mode_q;
    hit_d    = hit_q;
    hitpos_d = hitpos_q;
    flags_d  = flags_q;
    pos_d    = pos_q;
    lo_n     = lo_q;
    hi_n     = hi_q;
    any_hit  = 1'b0;
    ram_we_o = 1'b0;
    ram_re_o = 1'b0;
    ram_raddr_o = mid_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          key_d   = in_key_i;
          mode_d  = stbs_pkg::cmd_e'(in_cmd_i);
          flags_d = '0;
          pos_d   = '0;
          hit_d   = 1'b0;
          state_d = ST_RESP;
          case (stbs_pkg::cmd_e'(in_cmd_i))
            stbs_pkg::CMD_APPEND: begin
              if (count_q >= CNT_W'(DEPTH)) begin
                flags_d.refused = 1'b1;
              end else begin
                // write the raw key straight from the input item
                ram_we_o = 1'b1;
                pos_d    = count_q[IDX_W-1:0];
                count_d  = count_q + CNT_W'(1);
              end
            end
            stbs_pkg::CMD_SEARCH_ANY,
            stbs_pkg::CMD_SEARCH_FIRST,
            stbs_pkg::CMD_SEARCH_LAST: begin
              lo_d = '0;
              hi_d = count_q;
              if (count_q != '0) begin
                mid_d       = half_cnt[IDX_W-1:0];
                ram_re_o    = 1'b1;
                ram_raddr_o = half_cnt[IDX_W-1:0];
                state_d     = ST_PROBE;
              end
            end
            stbs_pkg::CMD_CLEAR: begin
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end

      ST_PROBE: begin
        // read data belongs to mid_q; narrow the range and issue the next probe, or finish on a hit or an empty range
        case (mode_q)
          stbs_pkg::CMD_SEARCH_ANY: begin
            if (eq) begin
              any_hit = 1'b1;
            end else if (lt) begin
              lo_n = mid_inc;
            end else begin
              hi_n = mid_ext;
            end
          end
          stbs_pkg::CMD_SEARCH_FIRST: begin
            if (lt) begin
              lo_n = mid_inc;
            end else begin
              hi_n     = mid_ext;
              hit_d    = eq;
              hitpos_d = mid_q;
            end
          end
          stbs_pkg::CMD_SEARCH_LAST: begin
            if (lt || eq) begin
              lo_n     = mid_inc;
              hit_d    = eq;
              hitpos_d = mid_q;
            end else begin
              hi_n = mid_ext;
            end
          end
          default: begin
          end
        endcase

        if (any_hit) begin
          flags_d.found = 1'b1;
          pos_d         = mid_q;
          state_d       = ST_RESP;
        end else if (lo_n < hi_n) begin
          lo_d        = lo_n;
          hi_d        = hi_n;
          mid_d       = next_mid[IDX_W-1:0];
          ram_re_o    = 1'b1;
          ram_raddr_o = next_mid[IDX_W-1:0];
        end else begin
          // bound entry was probed on the last move of that bound
          flags_d.found = hit_d;
          pos_d         = hit_d ? hitpos_d : '0;
          state_d       = ST_RESP;
        end
      end

      ST_RESP: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    key_q    <= key_d;
    mode_q   <= mode_d;
    hit_q    <= hit_d;
    hitpos_q <= hitpos_d;
    flags_q  <= flags_d;
    pos_q    <= pos_d;
  end

endmodule

`default_nettype wire

// ===== rtl/sorted_table_binary_search.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake                  Payload
// s_axis    in   s_axis_tvalid/tready       tdata[31:0] value, tuser[2:0] command
// m_axis    out  m_axis_tvalid/tready       tdata[9:0] position, tuser[0] found,
//                                           tuser[1] refused
//
// Append, clear and unknown commands go from accept straight to result hand-off.
// A search over n entries makes P <= floor(log2(n)) + 1 probes, one per cycle,
// set by the single read port of the table memory.
// Reset clears the entry count; the table is not cleared and needs no sweep.
// One item is worked at a time; the output register holds a result while the
// next item proceeds; a finished item waits while that register is full and undrained.

module sorted_table_binary_search #(
  parameter int unsigned DEPTH       = 1024,
  parameter int unsigned ENTRY_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,   // [31:0] value
  input  wire logic [2:0]  s_axis_tuser_i,   // [2:0] command
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [15:0] m_axis_tdata_o,   // [9:0] position, [15:10] zero
  output logic      [1:0]  m_axis_tuser_o    // [0] found, [1] refused
);

  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned PEXT_W = IDX_W + stbs_pkg::POS_W;
  localparam int unsigned VEXT_W = ENTRY_WIDTH + stbs_pkg::VALUE_W;

  logic                      in_ready;
  logic [VEXT_W-1:0]         val_ext;
  logic [ENTRY_WIDTH-1:0]    in_key;
  logic                      res_valid, res_ready;
  stbs_pkg::res_flags_t      res_flags;
  logic [IDX_W-1:0]          res_pos;
  logic [PEXT_W-1:0]         pos_ext;
  logic                      ram_we, ram_re;
  logic [IDX_W-1:0]          ram_waddr, ram_raddr;
  logic [ENTRY_WIDTH-1:0]    ram_wdata, ram_rdata;

  logic                      out_valid_q, out_valid_d;
  stbs_pkg::res_flags_t      out_flags_q;
  logic [stbs_pkg::POS_W-1:0] out_pos_q;

  // sign-extend, then keep the low entry bits
  assign val_ext = {{ENTRY_WIDTH{s_axis_tdata_i[31]}}, s_axis_tdata_i};
  assign in_key  = val_ext[ENTRY_WIDTH-1:0];

  assign s_axis_tready_o = in_ready;

  stbs_ctrl #(
    .DEPTH       (DEPTH),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (in_ready),
    .in_cmd_i    (s_axis_tuser_i),
    .in_key_i    (in_key),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_flags_o (res_flags),
    .res_pos_o   (res_pos),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // writes happen only on accept and reads only while searching: no overlap
  stbs_ram #(
    .WIDTH (ENTRY_WIDTH),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // output register: load when empty or being drained
  assign res_ready   = !out_valid_q || m_axis_tready_i;
  assign pos_ext     = PEXT_W'(res_pos);
  assign out_valid_d = (res_valid && res_ready) ? 1'b1
                     : (m_axis_tready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_flags_q <= res_flags;
      out_pos_q   <= pos_ext[stbs_pkg::POS_W-1:0];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(16 - stbs_pkg::POS_W)'(0), out_pos_q};
  assign m_axis_tuser_o  = out_flags_q;

  // the append path writes the key of the item being accepted
  a_wdata_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (ram_wdata == in_key))
    else $error("table write data differs from accepted key");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("second item accepted while one is in work");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready && res_valid) && !(ram_we && ram_re && !in_ready))
    else $error("control accepts while a result is pending");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_ready) |=> m_axis_tvalid_o)
    else $error("result handed off but output not valid");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tuser_o[0] && m_axis_tuser_o[1]))
    else $error("found and refused both set");

endmodule

`default_nettype wire
